// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Each macro is clocked on aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SMF_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types of the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int MAX_HALF     = 7;
    localparam int SAMPLE_WIDTH = 16;
    localparam int HALF_W       = 3;
    localparam int STORE_DEPTH  = 2 * MAX_HALF + 1;
    localparam int COUNT_W      = $clog2(STORE_DEPTH + 1);
    localparam int RANK_W       = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(STORE_DEPTH + MAX_HALF + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef sample_t [STORE_DEPTH-1:0]      taps_t;
    typedef logic [HALF_W-1:0]              half_t;

    // Update request for the window store.
    typedef struct packed {
        logic    shift;
        logic    fill;
        sample_t data;
    } store_ctrl_t;

    // One filtered beat.
    typedef struct packed {
        sample_t median;
        logic    last;
    } result_t;

endpackage

// ===== design/smf_window.sv =====
// ----------------------------------------------------------------------------
// smf_window
// Window store: a shift line of samples with the newest at the top tap.
// ----------------------------------------------------------------------------
module smf_window (
    input  logic                 aclk,
    input  smf_pkg::store_ctrl_t ctrl,
    output smf_pkg::taps_t       taps
);

    smf_pkg::taps_t taps_reg;

    // Fill all taps on a signal's first sample, shift on ctrl.shift, else hold.
    always_ff @(posedge aclk) begin
        if (ctrl.fill) begin
            taps_reg <= {smf_pkg::STORE_DEPTH{ctrl.data}};
        end else if (ctrl.shift) begin
            taps_reg <= {ctrl.data, taps_reg[smf_pkg::STORE_DEPTH-1:1]};
        end
    end

    assign taps = taps_reg;

endmodule

// ===== design/smf_median.sv =====
// ----------------------------------------------------------------------------
// smf_median
// Rank-compare median over the newest 2*half_window+1 taps.
// ----------------------------------------------------------------------------
module smf_median (
    input  smf_pkg::taps_t   taps,
    input  smf_pkg::half_t   half_window,
    output smf_pkg::sample_t median
);

    logic [smf_pkg::RANK_W-1:0]      win_lo;
    logic [smf_pkg::STORE_DEPTH-1:0] in_win;
    logic [smf_pkg::STORE_DEPTH-1:0] sel;
    logic [smf_pkg::RANK_W-1:0]      rank [smf_pkg::STORE_DEPTH];
    logic [smf_pkg::STORE_DEPTH-1:0] beats [smf_pkg::STORE_DEPTH];

    // Lowest tap that belongs to the window.
    assign win_lo = smf_pkg::RANK_W'(smf_pkg::STORE_DEPTH - 1)
                  - smf_pkg::RANK_W'({half_window, 1'b0});

    // Each tap counts the window members that sort ahead of it. Ties are
    // broken by tap position, so the ranks are distinct.
    always_comb begin
        for (int i = 0; i < smf_pkg::STORE_DEPTH; i++) begin
            in_win[i] = (smf_pkg::RANK_W'(i) >= win_lo);
        end
        for (int i = 0; i < smf_pkg::STORE_DEPTH; i++) begin
            rank[i] = '0;
            for (int j = 0; j < smf_pkg::STORE_DEPTH; j++) begin
                beats[i][j] = (j != i) && in_win[j] &&
                              (($signed(taps[j]) < $signed(taps[i])) ||
                               ((taps[j] == taps[i]) && (j < i)));
                rank[i] = rank[i] + smf_pkg::RANK_W'(beats[i][j]);
            end
            sel[i] = in_win[i] && (rank[i] == smf_pkg::RANK_W'(half_window));
        end
    end

    // The tap ranked half_window is the median.
    always_comb begin
        median = '0;
        for (int i = 0; i < smf_pkg::STORE_DEPTH; i++) begin
            median = median | (taps[i] & {smf_pkg::SAMPLE_WIDTH{sel[i]}});
        end
    end

endmodule

// ===== design/smf_out_stage.sv =====
// ----------------------------------------------------------------------------
// smf_out_stage
// Result register that holds one beat until the consumer takes it.
// ----------------------------------------------------------------------------
module smf_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  smf_pkg::result_t result,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output smf_pkg::sample_t m_median_out,
    output logic             m_last_out
);

    logic             valid_reg;
    smf_pkg::result_t data_reg;

    // The register can take a beat when empty or being drained.
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid      = valid_reg;
    assign m_median_out = data_reg.median;
    assign m_last_out   = data_reg.last;

endmodule

// ===== design/sliding_median_filter.sv =====
// A released median is registered in the window stage, then in the result register.
// Throughput: one sample per cycle while the output does not stall; a sample marked last
// holds off the input while half_window padded tail steps are flushed, one per cycle.
// The period is set by the 15-tap rank compare between window store and result register.
// Reset clears the sample count, flush state and output valid and sets half_window to 1;
// the window store is not reset, since the first sample of a signal fills it.
// ----------------------------------------------------------------------------
// sliding_median_filter
// Edge-padded one-dimensional median filter with a programmable window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_median_filter (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [smf_pkg::HALF_W-1:0] cfg_half_window,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [smf_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                   s_last_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [smf_pkg::SAMPLE_WIDTH-1:0] m_median_out,
    output logic                   m_last_out
);

    smf_pkg::half_t              half_window_reg;
    logic [smf_pkg::COUNT_W-1:0] held_count_reg, held_count_next;
    logic [smf_pkg::HALF_W-1:0]  flush_left_reg, flush_left_next;
    logic [smf_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        emit_reg, emit_next;
    logic                        emit_last_reg, emit_last_next;

    logic                 accept;
    logic                 flushing;
    logic                 flush_step;
    logic                 out_free;
    logic                 a_adv;
    logic                 a_free;
    smf_pkg::store_ctrl_t store_ctrl;
    smf_pkg::taps_t       taps;
    smf_pkg::sample_t     median_val;
    smf_pkg::result_t     result;

    // Configuration register; writes above the largest window saturate.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_window_reg <= smf_pkg::half_t'(1);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_half_window > smf_pkg::HALF_W'(smf_pkg::MAX_HALF)) begin
                half_window_reg <= smf_pkg::HALF_W'(smf_pkg::MAX_HALF);
            end else begin
                half_window_reg <= cfg_half_window;
            end
        end
    end

    // Handshake: the window stage moves when empty or when its beat goes to the result register.
    assign a_adv      = emit_reg && out_free;
    assign a_free     = !emit_reg || a_adv;
    assign flushing   = (flush_left_reg != '0);
    assign s_ready    = a_free && !flushing;
    assign accept     = s_valid && s_ready;
    assign flush_step = a_free && flushing;

    // Store update: new sample, or the top sample repeated during a flush.
    always_comb begin
        store_ctrl.fill  = accept && (held_count_reg == '0);
        store_ctrl.shift = (accept && (held_count_reg != '0)) || flush_step;
        store_ctrl.data  = accept ? s_sample : taps[smf_pkg::STORE_DEPTH-1];
    end

    // Sequencing of counts, flush and the emit flag of the window stage.
    always_comb begin
        held_count_next = held_count_reg;
        flush_left_next = flush_left_reg;
        pos_next        = pos_reg;
        emit_next       = emit_reg;
        emit_last_next  = emit_last_reg;
        if (a_free) begin
            emit_next      = 1'b0;
            emit_last_next = 1'b0;
        end
        if (accept) begin
            emit_next      = (held_count_reg >= smf_pkg::COUNT_W'(half_window_reg));
            emit_last_next = s_last_in && (half_window_reg == '0);
            if (s_last_in) begin
                held_count_next = '0;
                flush_left_next = half_window_reg;
                pos_next        = smf_pkg::POS_W'(held_count_reg) + smf_pkg::POS_W'(1);
            end else if (held_count_reg < smf_pkg::COUNT_W'(smf_pkg::STORE_DEPTH)) begin
                held_count_next = held_count_reg + smf_pkg::COUNT_W'(1);
            end
        end else if (flush_step) begin
            emit_next       = (pos_reg >= smf_pkg::POS_W'(half_window_reg));
            emit_last_next  = (flush_left_reg == smf_pkg::HALF_W'(1));
            flush_left_next = flush_left_reg - smf_pkg::HALF_W'(1);
            pos_next        = pos_reg + smf_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            flush_left_reg <= '0;
            pos_reg        <= '0;
            emit_reg       <= 1'b0;
            emit_last_reg  <= 1'b0;
        end else begin
            held_count_reg <= held_count_next;
            flush_left_reg <= flush_left_next;
            pos_reg        <= pos_next;
            emit_reg       <= emit_next;
            emit_last_reg  <= emit_last_next;
        end
    end

    smf_window u_window (
        .aclk (aclk),
        .ctrl (store_ctrl),
        .taps (taps)
    );

    smf_median u_median (
        .taps        (taps),
        .half_window (half_window_reg),
        .median      (median_val)
    );

    assign result = {median_val, emit_last_reg};

    smf_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (a_adv),
        .result       (result),
        .free         (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_median_out (m_median_out),
        .m_last_out   (m_last_out)
    );

    // A flush only runs after a last sample, which ends the signal.
    `SMF_ASSERT_HOLDS(a_flush_idle_count, flushing, held_count_reg == '0, "flush with count set")
    // A last sample always ends the current signal.
    `SMF_ASSERT_NEXT(a_last_clears, accept && s_last_in, held_count_reg == '0, "count not cleared")
    // The store must hold while its window waits for the result register.
    `SMF_ASSERT_NEXT(a_store_hold, emit_reg && !a_adv, $stable(taps), "store moved under stall")
    // A last sample schedules exactly half_window flush steps.
    `SMF_ASSERT_NEXT(a_flush_len, accept && s_last_in,
        flush_left_reg == $past(half_window_reg), "wrong flush length")

endmodule

// ===== tb/sliding_median_filter_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_median_filter_tb
// Self-checking bench for the edge-padded sliding median filter. Samples are
// sent as signals of random length and content. A behavioral predictor keeps
// its own window store, sample count and window setting, and the expected
// medians are queued. Each result beat is checked against the queue. The run
// covers every window size, short signals, window changes in the middle of a
// signal, saturated sample counts, random idling on both sides and a long
// output stall that fills the block.
// ----------------------------------------------------------------------------
module sliding_median_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = smf_pkg::MAX_HALF + 6;
    localparam int HOLD_CYCLES   = 80;

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    smf_pkg::half_t   cfg_half_window;
    logic             s_valid;
    logic             s_ready;
    smf_pkg::sample_t s_sample;
    logic             s_last_in;
    logic             m_valid;
    logic             m_ready;
    smf_pkg::sample_t m_median_out;
    logic             m_last_out;

    // Predictor state: window store with the newest sample at the top.
    smf_pkg::sample_t taps [smf_pkg::STORE_DEPTH];
    int               samples_held;
    int               window_half;
    smf_pkg::result_t pending_medians [$];

    // Run bookkeeping.
    int               errors;
    int               samples_sent;
    int               beats_checked;
    int               signals_sent;
    int               settings_written;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_left;
    smf_pkg::result_t oldest_median;

    sliding_median_filter uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_half_window (cfg_half_window),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_last_in       (s_last_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median_out    (m_median_out),
        .m_last_out      (m_last_out)
    );

    // Clock.
    always #HALF_PERIOD aclk = ~aclk;

    // Shift one sample into the predicted window store.
    function automatic void push_tap(smf_pkg::sample_t smp);
        for (int k = 0; k < smf_pkg::STORE_DEPTH - 1; k++) begin
            taps[k] = taps[k + 1];
        end
        taps[smf_pkg::STORE_DEPTH - 1] = smp;
    endfunction

    // Median of the newest 2*h+1 stored samples, by insertion sort.
    function automatic smf_pkg::sample_t window_median(int h);
        smf_pkg::sample_t sorted [smf_pkg::STORE_DEPTH];
        smf_pkg::sample_t key;
        int               w;
        int               j;
        w = 2 * h + 1;
        for (int i = 0; i < w; i++) begin
            sorted[i] = taps[smf_pkg::STORE_DEPTH - w + i];
        end
        for (int i = 1; i < w; i++) begin
            key = sorted[i];
            j   = i;
            while (j > 0 && sorted[j - 1] > key) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[h];
    endfunction

    // Queue every median that one accepted sample releases.
    function automatic void predict_medians(smf_pkg::sample_t smp, logic lst);
        int               prev;
        int               stop;
        smf_pkg::result_t beat;
        prev = samples_held;
        if (prev == 0) begin
            for (int k = 0; k < smf_pkg::STORE_DEPTH; k++) begin
                taps[k] = smp;
            end
        end else begin
            push_tap(smp);
        end
        stop = lst ? window_half : 0;
        for (int j = 0; j <= stop; j++) begin
            if (j > 0) begin
                push_tap(smp);
            end
            if (prev + j >= window_half) begin
                beat.median = window_median(window_half);
                beat.last   = lst && (j == stop);
                pending_medians.insert(pending_medians.size(), beat);
            end
        end
        if (lst) begin
            samples_held = 0;
        end else if (prev < smf_pkg::STORE_DEPTH) begin
            samples_held = prev + 1;
        end
    endfunction

    // Offer one sample, with random idle cycles ahead of it.
    task automatic send_sample(smf_pkg::sample_t smp, logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= smp;
        s_last_in <= lst;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        predict_medians(smp, lst);
        samples_sent++;
        if (lst) signals_sent++;
    endtask

    // Stop offering samples and wait until the block has nothing in flight.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_medians.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the window register; the caller makes sure the block is idle.
    task automatic write_half_window(int value);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_half_window <= smf_pkg::half_t'(value);
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        window_half = (value > smf_pkg::MAX_HALF) ? smf_pkg::MAX_HALF : value;
        settings_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Sample content: full range, a narrow band full of ties, or extremes only.
    function automatic smf_pkg::sample_t pick_sample(int mode);
        case (mode)
            0: return smf_pkg::sample_t'($urandom);
            1: return smf_pkg::sample_t'($signed($urandom_range(8)) - 4);
            default: begin
                case ($urandom_range(3))
                    0: return smf_pkg::sample_t'(16'sh7fff);
                    1: return smf_pkg::sample_t'(16'sh8000);
                    2: return smf_pkg::sample_t'(0);
                    default: return smf_pkg::sample_t'(-1);
                endcase
            end
        endcase
    endfunction

    // Reset value of the window: three samples with half_window still at one.
    task automatic test_reset_window();
        send_sample(16'sd300, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'sd42, 1'b1);
        wait_idle();
    endtask

    // Smallest and largest windows with extreme sample values.
    task automatic test_window_extremes();
        write_half_window(0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b1);
        wait_idle();
        // Single-sample signal and a short signal, padded on both sides.
        write_half_window(smf_pkg::MAX_HALF);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        wait_idle();
    endtask

    // Window grows and then shrinks while a signal is in progress.
    task automatic test_mid_signal_change();
        write_half_window(2);
        for (int k = 0; k < 4; k++) begin
            send_sample(smf_pkg::sample_t'(k * 1000 - 1500), 1'b0);
        end
        wait_idle();
        write_half_window(5);
        send_sample(16'sd7, 1'b0);
        send_sample(-16'sd7, 1'b0);
        wait_idle();
        write_half_window(1);
        send_sample(16'sd99, 1'b1);
        wait_idle();
    endtask

    // Long output stall while a long signal is offered, so the input backs up.
    task automatic test_backpressure();
        set_idling(0, 0);
        write_half_window(smf_pkg::MAX_HALF);
        hold_left = HOLD_CYCLES;
        for (int k = 0; k < 24; k++) begin
            send_sample(pick_sample(0), k == 23);
        end
        wait_idle();
    endtask

    // Random signals, with window changes at boundaries and mid-signal.
    task automatic test_random_signals(int n_items, int send_pct, int recv_pct);
        int sent;
        int len;
        int mode;
        set_idling(send_pct, recv_pct);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(40, 16);
            end else begin
                len = $urandom_range(12, 1);
            end
            if (len > n_items - sent) len = n_items - sent;
            mode = $urandom_range(2);
            if ($urandom_range(99) < 30) begin
                wait_idle();
                write_half_window($urandom_range(smf_pkg::MAX_HALF));
            end
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(99) < 3) begin
                    wait_idle();
                    write_half_window($urandom_range(smf_pkg::MAX_HALF));
                end
                send_sample(pick_sample(mode), k == len - 1);
            end
            sent += len;
        end
        wait_idle();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result beat with the oldest predicted median.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                $error("unexpected beat: median_out %0d, last_out %0b",
                       m_median_out, m_last_out);
                errors++;
            end else begin
                oldest_median = pending_medians.pop_front();
                beats_checked++;
                if (m_median_out !== oldest_median.median) begin
                    $error("median_out: expected %0d, got %0d",
                           oldest_median.median, m_median_out);
                    errors++;
                end
                if (m_last_out !== oldest_median.last) begin
                    $error("last_out: expected %0b, got %0b",
                           oldest_median.last, m_last_out);
                    errors++;
                end
            end
        end
    end

    // Run time limit.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_half_window  = '0;
        s_valid          = 1'b0;
        s_sample         = '0;
        s_last_in        = 1'b0;
        m_ready          = 1'b0;
        samples_held     = 0;
        window_half      = 1;
        errors           = 0;
        samples_sent     = 0;
        beats_checked    = 0;
        signals_sent     = 0;
        settings_written = 0;
        hold_left        = 0;
        set_idling(0, 0);
        for (int k = 0; k < smf_pkg::STORE_DEPTH; k++) taps[k] = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_window();
        test_window_extremes();
        test_mid_signal_change();
        test_backpressure();
        test_random_signals(50, 0, 0);
        test_random_signals(50, 56, 0);
        test_random_signals(50, 0, 56);
        test_random_signals(50, 25, 25);

        wait_idle();
        $display("summary: %0d samples in %0d signals, %0d medians checked",
                 samples_sent, signals_sent, beats_checked);
        $display("summary: %0d window writes, idling and a %0d-cycle output hold-off",
                 settings_written, HOLD_CYCLES);
        if (errors == 0 && pending_medians.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
